@@ sv/ascii_line_to_integer_unit_macros.svh @@
// Assertion macros for the ASCII line to integer unit.
`ifndef ASCII_LINE_TO_INTEGER_UNIT_MACROS_SVH
`define ASCII_LINE_TO_INTEGER_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define ALTOI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ALTOI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ALTOI_ASSERT_NOW(lbl, ante, cons)
`define ALTOI_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ sv/altoi_pkg.sv @@
// Types and constants shared by the ASCII line to integer unit.
package altoi_pkg;

    localparam int LINE_CHARS = 16;
    localparam int CNT_W      = 5;
    localparam int VALUE_W    = 32;

    typedef logic [7:0]         char_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [VALUE_W-1:0] acc_t;

    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_UNDER = 8'h5f;
    localparam char_t CH_MINUS = 8'h2d;
    localparam char_t CH_0     = 8'h30;
    localparam char_t CH_9     = 8'h39;
    localparam char_t CH_UA    = 8'h41;
    localparam char_t CH_UF    = 8'h46;
    localparam char_t CH_LA    = 8'h61;
    localparam char_t CH_LF_HX = 8'h66;
    localparam char_t CH_NL    = 8'h0a;
    localparam char_t CH_CR    = 8'h0d;
    localparam char_t CH_GT    = 8'h3e;

    // Result of one parser step.
    typedef struct packed {
        logic                      emit;
        logic                      line_full;
        logic signed [VALUE_W-1:0] value;
    } result_t;

endpackage

@@ sv/ascii_line_to_integer_unit.sv @@
// Character-stream number parser: one ASCII byte per beat in, one signed
// 32-bit value per line out. A beat is taken every cycle as long as the
// result register is free or the character ends no line; a result can be
// taken once the beat that ends its line has passed the input register and
// the parser update into the result register. The rate is set by the single
// accumulator update, one character per cycle while no result is held up.
`include "ascii_line_to_integer_unit_macros.svh"

module ascii_line_to_integer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // hex_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] value
    output logic        m_axis_tuser   // [0] line_full
);
    import altoi_pkg::*;

    logic    hex_mode_reg;
    logic    in_valid;
    char_t   in_char;
    logic    step;
    logic    out_free;
    result_t res;

    logic                      m_valid_reg;
    logic signed [VALUE_W-1:0] m_value_reg;
    logic                      m_full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hex_mode_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            hex_mode_reg <= cfg_wr_data;
        end
    end

    altoi_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_char    (s_axis_tdata),
        .take      (step),
        .valid     (in_valid),
        .char_code (in_char)
    );

    altoi_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .hex_mode  (hex_mode_reg),
        .char_code (in_char),
        .res       (res)
    );

    // advance only when a produced result has somewhere to go
    assign out_free = !m_valid_reg || m_axis_tready;
    assign step     = in_valid && (!res.emit || out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= step && res.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && step && res.emit) begin
            m_value_reg <= res.value;
            m_full_reg  <= res.line_full;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_value_reg;
    assign m_axis_tuser  = m_full_reg;

    `ALTOI_ASSERT_NOW(a_stall_only_when_full, !s_axis_tready, in_valid)
    `ALTOI_ASSERT_NOW(a_no_result_overwrite, step && res.emit, out_free)
    `ALTOI_ASSERT_NEXT(a_pending_result_kept, m_valid_reg && !m_axis_tready, m_valid_reg)

endmodule

@@ sv/altoi_in_stage.sv @@
// Input register for incoming character beats.
module altoi_in_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  altoi_pkg::char_t s_char,
    input  logic             take,
    output logic             valid,
    output altoi_pkg::char_t char_code
);
    import altoi_pkg::*;

    logic  valid_reg;
    char_t char_reg;

    assign s_tready  = !valid_reg || take;
    assign valid     = valid_reg;
    assign char_code = char_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            char_reg <= s_char;
        end
    end

endmodule

@@ sv/altoi_parser.sv @@
// Line parser state and its one-character update.
module altoi_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic               hex_mode,
    input  altoi_pkg::char_t   char_code,
    output altoi_pkg::result_t res
);
    import altoi_pkg::*;

    acc_t   acc_reg,   acc_next;
    logic   neg_reg,   neg_next;
    logic   blank_reg, blank_next;
    logic   stop_reg,  stop_next;
    count_t cnt_reg,   cnt_next;

    acc_t       acc_take;
    logic       neg_take, blank_take, stop_take;
    logic [3:0] digit;
    logic       is_digit;
    count_t     cnt_inc;

    always_comb begin
        acc_take   = acc_reg;
        neg_take   = neg_reg;
        blank_take = blank_reg;
        stop_take  = stop_reg;
        digit      = 4'd0;
        is_digit   = 1'b0;

        if (char_code inside {[CH_0:CH_9]}) begin
            digit    = 4'(char_code - CH_0);
            is_digit = 1'b1;
        end else if (hex_mode && (char_code inside {[CH_UA:CH_UF]})) begin
            digit    = 4'(char_code - CH_UA + 8'd10);
            is_digit = 1'b1;
        end else if (hex_mode && (char_code inside {[CH_LA:CH_LF_HX]})) begin
            digit    = 4'(char_code - CH_LA + 8'd10);
            is_digit = 1'b1;
        end

        if (!stop_reg) begin
            if (char_code inside {CH_SPACE, CH_UNDER}) begin
                if (!blank_reg) begin
                    stop_take = 1'b1;
                end
            end else if (char_code == CH_MINUS) begin
                if (!blank_reg) begin
                    stop_take = 1'b1;
                end else begin
                    neg_take   = 1'b1;
                    blank_take = 1'b0;
                end
            end else if (is_digit) begin
                // x16 is a shift; x10 is x8 + x2
                if (hex_mode) begin
                    acc_take = (acc_reg << 4) + acc_t'(digit);
                end else begin
                    acc_take = (acc_reg << 3) + (acc_reg << 1) + acc_t'(digit);
                end
            end else begin
                stop_take = 1'b1;
            end
        end
    end

    always_comb begin
        cnt_inc        = cnt_reg + count_t'(1);
        acc_next       = acc_take;
        neg_next       = neg_take;
        blank_next     = blank_take;
        stop_next      = stop_take;
        cnt_next       = cnt_inc;
        res.emit       = 1'b0;
        res.line_full  = 1'b0;
        res.value      = neg_take ? -acc_take : acc_take;

        if (char_code inside {CH_GT, CH_NL, CH_CR}) begin
            // terminator is not counted and ends the line as it stands
            res.emit  = 1'b1;
            res.value = neg_reg ? -acc_reg : acc_reg;
        end else if (cnt_inc >= count_t'(LINE_CHARS)) begin
            res.emit      = 1'b1;
            res.line_full = 1'b1;
        end

        if (res.emit) begin
            acc_next   = '0;
            neg_next   = 1'b0;
            blank_next = 1'b1;
            stop_next  = 1'b0;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            blank_reg <= 1'b1;
            stop_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else if (step) begin
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            blank_reg <= blank_next;
            stop_reg  <= stop_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
